// ----- hdl/dafm_pkg.sv -----
// Shared constants and types for the dual audio FIFO mixer.
`timescale 1ns / 1ps

package dafm_pkg;

    localparam int FIFO_DEPTH = 16384;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int MODE_W     = 2;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_PRI = 2'd0,
        MODE_PUSH_SEC = 2'd1,
        MODE_PULL     = 2'd2
    } t_mode;

    typedef logic [PTR_W-1:0]           t_ptr;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    function automatic t_ptr ptr_next(input t_ptr p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

// ----- hdl/dual_audio_fifo_saturating_mixer_top.sv -----
// Dual sample FIFO pair with a saturating mixer on pull.
//
// Channel   Signals                                   Handshake
// --------  ----------------------------------------  --------------------------
// command   i_mode, i_sample                          start high, busy low
// result    o_mixed_sample, o_accepted,               o_valid, one cycle,
//           o_primary_underrun, o_secondary_underrun  no backpressure
//
// On a push the store is written at the accepting edge and the result shows in
// the next cycle. On a pull both stores are read at the accepting edge into
// registered read outputs, busy is then high in ST_MIX while the samples are
// mixed, and the result shows after that state.
// Synchronous reset clears pointers and held samples; the stores need no clear.
// The receiver cannot stall, so each result lasts exactly one cycle.
`timescale 1ns / 1ps

module dual_audio_fifo_saturating_mixer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dafm_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [dafm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_valid,
    output logic signed [dafm_pkg::SAMPLE_W-1:0] o_mixed_sample,
    output logic                                o_accepted,
    output logic                                o_primary_underrun,
    output logic                                o_secondary_underrun
);
    import dafm_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_MIX
    } t_state;

    t_state  r_state;
    t_ptr    r_pri_rd, r_pri_wr, r_sec_rd, r_sec_wr;
    t_sample r_pri_hold, r_sec_hold;
    t_sample r_pri_q, r_sec_q;
    logic    r_pri_empty, r_sec_empty;
    t_sample r_pri_mem [FIFO_DEPTH];
    t_sample r_sec_mem [FIFO_DEPTH];

    logic    take;
    t_mode   mode;
    logic    pri_empty, sec_empty, pri_full, sec_full;
    logic    pri_we, sec_we, pull_go;
    t_sample n_pri_val, n_sec_val;
    logic signed [SAMPLE_W:0] sum;
    t_sample n_mixed;

    assign busy      = (r_state == ST_MIX);
    assign take      = start && !busy;
    assign mode      = t_mode'(i_mode);
    assign pri_empty = (r_pri_rd == r_pri_wr);
    assign sec_empty = (r_sec_rd == r_sec_wr);
    assign pri_full  = (ptr_next(r_pri_wr) == r_pri_rd);
    assign sec_full  = (ptr_next(r_sec_wr) == r_sec_rd);
    assign pri_we    = take && (mode == MODE_PUSH_PRI) && !pri_full;
    assign sec_we    = take && (mode == MODE_PUSH_SEC) && !sec_full;
    assign pull_go   = take && (mode == MODE_PULL);

    assign n_pri_val = r_pri_empty ? r_pri_hold : r_pri_q;
    assign n_sec_val = r_sec_empty ? r_sec_hold : r_sec_q;
    assign sum       = {n_pri_val[SAMPLE_W-1], n_pri_val} + {n_sec_val[SAMPLE_W-1], n_sec_val};

    always_comb begin
        if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
            n_mixed = sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            n_mixed = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pri_we) begin
            r_pri_mem[r_pri_wr] <= i_sample;
        end
        r_pri_q <= r_pri_mem[r_pri_rd];
    end

    always_ff @(posedge i_clk) begin
        if (sec_we) begin
            r_sec_mem[r_sec_wr] <= i_sample;
        end
        r_sec_q <= r_sec_mem[r_sec_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state              <= ST_IDLE;
            r_pri_rd             <= '0;
            r_pri_wr             <= '0;
            r_sec_rd             <= '0;
            r_sec_wr             <= '0;
            r_pri_hold           <= '0;
            r_sec_hold           <= '0;
            r_pri_empty          <= 1'b0;
            r_sec_empty          <= 1'b0;
            o_valid              <= 1'b0;
            o_mixed_sample       <= '0;
            o_accepted           <= 1'b0;
            o_primary_underrun   <= 1'b0;
            o_secondary_underrun <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        o_mixed_sample       <= '0;
                        o_accepted           <= 1'b0;
                        o_primary_underrun   <= 1'b0;
                        o_secondary_underrun <= 1'b0;
                        if (pri_we) begin
                            r_pri_wr <= ptr_next(r_pri_wr);
                        end
                        if (sec_we) begin
                            r_sec_wr <= ptr_next(r_sec_wr);
                        end
                        if (pull_go) begin
                            r_pri_empty <= pri_empty;
                            r_sec_empty <= sec_empty;
                            if (!pri_empty) begin
                                r_pri_rd <= ptr_next(r_pri_rd);
                            end
                            if (!sec_empty) begin
                                r_sec_rd <= ptr_next(r_sec_rd);
                            end
                            r_state <= ST_MIX;
                        end else begin
                            o_accepted <= pri_we || sec_we;
                            o_valid    <= 1'b1;
                        end
                    end
                end
                ST_MIX: begin
                    r_pri_hold           <= n_pri_val;
                    r_sec_hold           <= n_sec_val;
                    o_mixed_sample       <= n_mixed;
                    o_primary_underrun   <= r_pri_empty;
                    o_secondary_underrun <= r_sec_empty;
                    o_valid              <= 1'b1;
                    r_state              <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
